// ----- rtl/core/obb_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and codes for the oriented box hit test.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int DEF_COORD_BITS  = 32;
    localparam int NUM_REGS        = 8;
    localparam int PIPE_DEPTH      = 6;

    typedef enum logic [2:0] {
        REG_LIN_A   = 3'd0,
        REG_LIN_B   = 3'd1,
        REG_LIN_C   = 3'd2,
        REG_LIN_D   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_HALF_W  = 3'd6,
        REG_HALF_H  = 3'd7
    } reg_idx_t;

    typedef enum logic {
        ACT_POINT = 1'b0,
        ACT_RECT  = 1'b1
    } action_t;

endpackage

// ----- rtl/core/oriented_box_hit_test_top.sv -----
// ----------------------------------------------------------------------------
// oriented_box_hit_test_top
// Point containment and rectangle overlap test against one oriented box.
// ----------------------------------------------------------------------------
// A query is taken on every cycle with start high (busy is always low) and
// its hit bit appears with done once it has passed the six-stage datapath
// (offset and transform products, determinant and world axis checks,
// edge-normal sums and absolute determinant, half extent scaling in two
// partial products, extent sum, final compares); one result per query,
// in order, at one query per clock. Results cannot be held off. Write the
// transform and half extents only while no query is in flight.
module oriented_box_hit_test_top #(
    parameter int COORD_BITS = obb_pkg::DEF_COORD_BITS,
    parameter int DW         = (COORD_BITS > 32) ? 64 : 32,
    parameter int AW         = (COORD_BITS > 32) ? 6 : 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [AW-1:0]                 paddr,
    input  logic [DW-1:0]                 pwdata,
    output logic [DW-1:0]                 prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic signed [COORD_BITS-1:0]  x_lo,
    input  logic signed [COORD_BITS-1:0]  y_lo,
    input  logic signed [COORD_BITS-1:0]  x_hi,
    input  logic signed [COORD_BITS-1:0]  y_hi,
    output logic                          done,
    output logic                          hit
);

    localparam int N  = COORD_BITS;
    localparam int F  = obb_pkg::FRAC_BITS;
    localparam int P  = N + 1;
    localparam int CW = 3 * N + F + 2;

    // configuration
    logic signed [N-1:0] lin_a_reg, lin_b_reg, lin_c_reg, lin_d_reg;
    logic signed [N-1:0] shift_x_reg, shift_y_reg;
    logic [N-2:0]        half_w_reg, half_h_reg;
    obb_pkg::reg_idx_t   cfg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = obb_pkg::reg_idx_t'(paddr[AW-1:AW-3]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_a_reg   <= N'(1 << F);
            lin_b_reg   <= '0;
            lin_c_reg   <= '0;
            lin_d_reg   <= N'(1 << F);
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            half_w_reg  <= '0;
            half_h_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                obb_pkg::REG_LIN_A:   lin_a_reg   <= pwdata[N-1:0];
                obb_pkg::REG_LIN_B:   lin_b_reg   <= pwdata[N-1:0];
                obb_pkg::REG_LIN_C:   lin_c_reg   <= pwdata[N-1:0];
                obb_pkg::REG_LIN_D:   lin_d_reg   <= pwdata[N-1:0];
                obb_pkg::REG_SHIFT_X: shift_x_reg <= pwdata[N-1:0];
                obb_pkg::REG_SHIFT_Y: shift_y_reg <= pwdata[N-1:0];
                obb_pkg::REG_HALF_W:  half_w_reg  <= pwdata[N-2:0];
                obb_pkg::REG_HALF_H:  half_h_reg  <= pwdata[N-2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            obb_pkg::REG_LIN_A:   prdata = DW'(lin_a_reg);
            obb_pkg::REG_LIN_B:   prdata = DW'(lin_b_reg);
            obb_pkg::REG_LIN_C:   prdata = DW'(lin_c_reg);
            obb_pkg::REG_LIN_D:   prdata = DW'(lin_d_reg);
            obb_pkg::REG_SHIFT_X: prdata = DW'(shift_x_reg);
            obb_pkg::REG_SHIFT_Y: prdata = DW'(shift_y_reg);
            obb_pkg::REG_HALF_W:  prdata = DW'(half_w_reg);
            obb_pkg::REG_HALF_H:  prdata = DW'(half_h_reg);
            default:              prdata = '0;
        endcase
    end

    // absolute transform terms
    logic [N-1:0] abs_a, abs_b, abs_c, abs_d;
    assign abs_a = lin_a_reg[N-1] ? (~lin_a_reg + 1'b1) : lin_a_reg;
    assign abs_b = lin_b_reg[N-1] ? (~lin_b_reg + 1'b1) : lin_b_reg;
    assign abs_c = lin_c_reg[N-1] ? (~lin_c_reg + 1'b1) : lin_c_reg;
    assign abs_d = lin_d_reg[N-1] ? (~lin_d_reg + 1'b1) : lin_d_reg;

    // stage 1: offsets, corner ordering, config products
    logic                v1_reg, v1_next, pt1_reg, pt1_next;
    logic signed [P-1:0] xa1_reg, xb1_reg, ya1_reg, yb1_reg;
    logic signed [P-1:0] xa1_next, xb1_next, ya1_next, yb1_next;
    logic signed [P-1:0] dxl, dxh, dyl, dyh;
    logic signed [2*N-1:0] ad1_reg, bc1_reg, ad1_next, bc1_next;
    logic [2*N-2:0] aw1_reg, ch1_reg, bw1_reg, dh1_reg;
    logic [2*N-2:0] aw1_next, ch1_next, bw1_next, dh1_next;

    always_comb
    begin
        dxl      = P'(x_lo) - P'(shift_x_reg);
        dxh      = P'(x_hi) - P'(shift_x_reg);
        dyl      = P'(y_lo) - P'(shift_y_reg);
        dyh      = P'(y_hi) - P'(shift_y_reg);
        v1_next  = start & ~busy;
        pt1_next = (action == obb_pkg::ACT_POINT);
        if (pt1_next)
        begin
            xa1_next = dxl;
            xb1_next = dxl;
            ya1_next = dyl;
            yb1_next = dyl;
        end
        else
        begin
            xa1_next = (x_lo <= x_hi) ? dxl : dxh;
            xb1_next = (x_lo <= x_hi) ? dxh : dxl;
            ya1_next = (y_lo <= y_hi) ? dyl : dyh;
            yb1_next = (y_lo <= y_hi) ? dyh : dyl;
        end
        ad1_next = (2*N)'(lin_a_reg) * (2*N)'(lin_d_reg);
        bc1_next = (2*N)'(lin_b_reg) * (2*N)'(lin_c_reg);
        aw1_next = (2*N-1)'(abs_a) * (2*N-1)'(half_w_reg);
        ch1_next = (2*N-1)'(abs_c) * (2*N-1)'(half_h_reg);
        bw1_next = (2*N-1)'(abs_b) * (2*N-1)'(half_w_reg);
        dh1_next = (2*N-1)'(abs_d) * (2*N-1)'(half_h_reg);
    end

    // stage 2: determinant, world axis checks, edge normal products
    logic                  v2_reg, pt2_reg, sep2_reg, sep2_next;
    logic signed [2*N:0]   det2_reg, det2_next;
    logic signed [2*N:0]   cylo2_reg, dxlo2_reg, cyhi2_reg, dxhi2_reg;
    logic signed [2*N:0]   aylo2_reg, bxlo2_reg, ayhi2_reg, bxhi2_reg;
    logic signed [2*N:0]   cylo2_next, dxlo2_next, cyhi2_next, dxhi2_next;
    logic signed [2*N:0]   aylo2_next, bxlo2_next, ayhi2_next, bxhi2_next;
    logic signed [CW-1:0]  ex_w, ey_w, xa_w, xb_w, ya_w, yb_w;

    always_comb
    begin
        det2_next = (2*N+1)'(ad1_reg) - (2*N+1)'(bc1_reg);
        ex_w = CW'(aw1_reg) + CW'(ch1_reg);
        ey_w = CW'(bw1_reg) + CW'(dh1_reg);
        xa_w = CW'(xa1_reg) <<< F;
        xb_w = CW'(xb1_reg) <<< F;
        ya_w = CW'(ya1_reg) <<< F;
        yb_w = CW'(yb1_reg) <<< F;
        sep2_next = (xb_w < -ex_w) || (xa_w > ex_w) || (yb_w < -ey_w) || (ya_w > ey_w);
        cylo2_next = (2*N+1)'(lin_c_reg) * (2*N+1)'(lin_c_reg[N-1] ? yb1_reg : ya1_reg);
        cyhi2_next = (2*N+1)'(lin_c_reg) * (2*N+1)'(lin_c_reg[N-1] ? ya1_reg : yb1_reg);
        dxlo2_next = (2*N+1)'(lin_d_reg) * (2*N+1)'(lin_d_reg[N-1] ? xa1_reg : xb1_reg);
        dxhi2_next = (2*N+1)'(lin_d_reg) * (2*N+1)'(lin_d_reg[N-1] ? xb1_reg : xa1_reg);
        aylo2_next = (2*N+1)'(lin_a_reg) * (2*N+1)'(lin_a_reg[N-1] ? yb1_reg : ya1_reg);
        ayhi2_next = (2*N+1)'(lin_a_reg) * (2*N+1)'(lin_a_reg[N-1] ? ya1_reg : yb1_reg);
        bxlo2_next = (2*N+1)'(lin_b_reg) * (2*N+1)'(lin_b_reg[N-1] ? xa1_reg : xb1_reg);
        bxhi2_next = (2*N+1)'(lin_b_reg) * (2*N+1)'(lin_b_reg[N-1] ? xb1_reg : xa1_reg);
    end

    // stage 3: absolute determinant, normal projection bounds
    logic                  v3_reg, pt3_reg, sep3_reg;
    logic [2*N-1:0]        adet3_reg, adet3_next;
    logic signed [2*N+1:0] n1lo3_reg, n1hi3_reg, n2lo3_reg, n2hi3_reg;
    logic signed [2*N+1:0] n1lo3_next, n1hi3_next, n2lo3_next, n2hi3_next;
    logic signed [2*N:0]   det_neg;

    always_comb
    begin
        det_neg    = -det2_reg;
        adet3_next = det2_reg[2*N] ? det_neg[2*N-1:0] : det2_reg[2*N-1:0];
        n1lo3_next = (2*N+2)'(cylo2_reg) - (2*N+2)'(dxlo2_reg);
        n1hi3_next = (2*N+2)'(cyhi2_reg) - (2*N+2)'(dxhi2_reg);
        n2lo3_next = (2*N+2)'(aylo2_reg) - (2*N+2)'(bxlo2_reg);
        n2hi3_next = (2*N+2)'(ayhi2_reg) - (2*N+2)'(bxhi2_reg);
    end

    // stage 4: half extents times |det|, two partial products each
    logic                  v4_reg, pt4_reg, sep4_reg, dz4_reg, dz4_next;
    logic [2*N-2:0]        wlo4_reg, whi4_reg, hlo4_reg, hhi4_reg;
    logic [2*N-2:0]        wlo4_next, whi4_next, hlo4_next, hhi4_next;
    logic signed [2*N+1:0] n1lo4_reg, n1hi4_reg, n2lo4_reg, n2hi4_reg;

    always_comb
    begin
        dz4_next  = (adet3_reg == '0);
        wlo4_next = (2*N-1)'(half_w_reg) * (2*N-1)'(adet3_reg[N-1:0]);
        whi4_next = (2*N-1)'(half_w_reg) * (2*N-1)'(adet3_reg[2*N-1:N]);
        hlo4_next = (2*N-1)'(half_h_reg) * (2*N-1)'(adet3_reg[N-1:0]);
        hhi4_next = (2*N-1)'(half_h_reg) * (2*N-1)'(adet3_reg[2*N-1:N]);
    end

    // stage 5: extent sums
    logic                  v5_reg, pt5_reg, sep5_reg, dz5_reg;
    logic [3*N-1:0]        ew5_reg, eh5_reg, ew5_next, eh5_next;
    logic signed [2*N+1:0] n1lo5_reg, n1hi5_reg, n2lo5_reg, n2hi5_reg;

    always_comb
    begin
        ew5_next = ((3*N)'(whi4_reg) << N) + (3*N)'(wlo4_reg);
        eh5_next = ((3*N)'(hhi4_reg) << N) + (3*N)'(hlo4_reg);
    end

    // stage 6: normal axis compares and result
    logic                 v6_reg, pt6_reg, dz6_reg, hit6_reg, hit6_next;
    logic signed [CW-1:0] ew_w, eh_w, n1lo_w, n1hi_w, n2lo_w, n2hi_w;
    logic                 ok1, ok2;

    always_comb
    begin
        ew_w   = CW'(ew5_reg);
        eh_w   = CW'(eh5_reg);
        n1lo_w = CW'(n1lo5_reg) <<< F;
        n1hi_w = CW'(n1hi5_reg) <<< F;
        n2lo_w = CW'(n2lo5_reg) <<< F;
        n2hi_w = CW'(n2hi5_reg) <<< F;
        ok1    = (n1hi_w >= -ew_w) && (n1lo_w <= ew_w);
        ok2    = (n2hi_w >= -eh_w) && (n2lo_w <= eh_w);
        if (pt5_reg)
            hit6_next = ~dz5_reg & ok1 & ok2;
        else
            hit6_next = ~sep5_reg & ok1 & ok2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pt1_reg   <= pt1_next;
        xa1_reg   <= xa1_next;
        xb1_reg   <= xb1_next;
        ya1_reg   <= ya1_next;
        yb1_reg   <= yb1_next;
        ad1_reg   <= ad1_next;
        bc1_reg   <= bc1_next;
        aw1_reg   <= aw1_next;
        ch1_reg   <= ch1_next;
        bw1_reg   <= bw1_next;
        dh1_reg   <= dh1_next;

        pt2_reg   <= pt1_reg;
        sep2_reg  <= sep2_next;
        det2_reg  <= det2_next;
        cylo2_reg <= cylo2_next;
        cyhi2_reg <= cyhi2_next;
        dxlo2_reg <= dxlo2_next;
        dxhi2_reg <= dxhi2_next;
        aylo2_reg <= aylo2_next;
        ayhi2_reg <= ayhi2_next;
        bxlo2_reg <= bxlo2_next;
        bxhi2_reg <= bxhi2_next;

        pt3_reg   <= pt2_reg;
        sep3_reg  <= sep2_reg;
        adet3_reg <= adet3_next;
        n1lo3_reg <= n1lo3_next;
        n1hi3_reg <= n1hi3_next;
        n2lo3_reg <= n2lo3_next;
        n2hi3_reg <= n2hi3_next;

        pt4_reg   <= pt3_reg;
        sep4_reg  <= sep3_reg;
        dz4_reg   <= dz4_next;
        wlo4_reg  <= wlo4_next;
        whi4_reg  <= whi4_next;
        hlo4_reg  <= hlo4_next;
        hhi4_reg  <= hhi4_next;
        n1lo4_reg <= n1lo3_reg;
        n1hi4_reg <= n1hi3_reg;
        n2lo4_reg <= n2lo3_reg;
        n2hi4_reg <= n2hi3_reg;

        pt5_reg   <= pt4_reg;
        sep5_reg  <= sep4_reg;
        dz5_reg   <= dz4_reg;
        ew5_reg   <= ew5_next;
        eh5_reg   <= eh5_next;
        n1lo5_reg <= n1lo4_reg;
        n1hi5_reg <= n1hi4_reg;
        n2lo5_reg <= n2lo4_reg;
        n2hi5_reg <= n2hi4_reg;

        pt6_reg   <= pt5_reg;
        dz6_reg   <= dz5_reg;
        hit6_reg  <= hit6_next;
    end

    assign done = v6_reg;
    assign hit  = hit6_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(obb_pkg::PIPE_DEPTH) done)
        else $error("transfer lost in pipeline");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(obb_pkg::PIPE_DEPTH) !done)
        else $error("result without transfer");

    a_singular_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pt6_reg && dz6_reg) |-> !hit)
        else $error("hit on singular transform");

endmodule
